[rtl/urh_pkg.sv]
package urh_pkg;

	// ring geometry of each side
	localparam int SIDE_DEPTH = 64;
	localparam int PTR_W      = $clog2(SIDE_DEPTH);
	localparam int CNT_W      = $clog2(SIDE_DEPTH + 1);
	localparam int SBYTES_W   = 24 + $clog2(SIDE_DEPTH);
	localparam int TBYTES_W   = SBYTES_W + 1;
	localparam int ECNT_W     = CNT_W + 1;
	localparam int ECMP_W     = (ECNT_W > 6) ? ECNT_W : 6;
	localparam int BCMP_W     = (TBYTES_W > 32) ? TBYTES_W : 32;

	// configuration register indexes
	localparam logic REG_MAX_ENTRIES = 1'b0;
	localparam logic REG_MAX_BYTES   = 1'b1;

	// command modes
	localparam logic [2:0] MODE_RECORD = 3'd0;
	localparam logic [2:0] MODE_UNDO   = 3'd1;
	localparam logic [2:0] MODE_REDO   = 3'd2;
	localparam logic [2:0] MODE_SAVE   = 3'd3;
	localparam logic [2:0] MODE_CLEAR  = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_UNDO = 2'd1;
	localparam logic [1:0] ST_NO_REDO = 2'd2;
	localparam logic [1:0] ST_FAIL    = 2'd3;

	// side select
	localparam logic SIDE_UNDO = 1'b0;
	localparam logic SIDE_REDO = 1'b1;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] image_handle;
		logic [23:0] image_bytes;
		logic        action_ok;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] restored_handle;
		logic [31:0] current_revision;
		logic        dirty;
		logic [6:0]  undo_count;
		logic [6:0]  redo_count;
		logic [31:0] bytes_in_use;
		logic [6:0]  evicted_count;
	} rsp_t;

	// one snapshot entry as stored in a side ring
	typedef struct packed {
		logic [15:0] handle;
		logic [23:0] bytes;
		logic [31:0] rev;
	} entry_t;

	// operations on one side ring
	typedef struct packed {
		logic clr;
		logic rd_newest;
		logic rd_oldest;
		logic pop_newest;
		logic drop_oldest;
		logic push;
	} side_cmd_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       rec;
		logic       rest;
		logic       save;
		logic       clr;
		logic       rd_new;
		logic       rd_old;
		logic       drop;
		logic       push;
		logic       side;
		logic       status_we;
		logic [1:0] status;
		logic       out_load;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] mode;
		logic       ok;
		logic       undo_empty;
		logic       redo_empty;
		logic       undo_full;
		logic       redo_full;
		logic       over;
		logic       pick_redo;
	} dp_stat_t;

endpackage

[rtl/urh_side.sv]
module urh_side (
	input  logic                           clk,
	input  logic                           arst_n,
	input  urh_pkg::side_cmd_t             cmd,
	input  urh_pkg::entry_t                push_entry,
	output urh_pkg::entry_t                rd_entry,
	output logic [urh_pkg::CNT_W-1:0]      count,
	output logic [urh_pkg::SBYTES_W-1:0]   bytes,
	output logic                           empty,
	output logic                           full
);

	localparam logic [urh_pkg::CNT_W:0]   DEPTH_X = (urh_pkg::CNT_W + 1)'(urh_pkg::SIDE_DEPTH);
	localparam logic [urh_pkg::PTR_W-1:0] LAST    = urh_pkg::PTR_W'(urh_pkg::SIDE_DEPTH - 1);

	urh_pkg::entry_t mem [urh_pkg::SIDE_DEPTH];

	logic [urh_pkg::PTR_W-1:0]    head_q;
	logic [urh_pkg::CNT_W-1:0]    count_q;
	logic [urh_pkg::SBYTES_W-1:0] bytes_q;
	urh_pkg::entry_t              rd_q;

	logic [urh_pkg::CNT_W:0]      tail_sum;
	logic [urh_pkg::CNT_W:0]      tail_wrap;
	logic [urh_pkg::PTR_W-1:0]    tail;
	logic [urh_pkg::PTR_W-1:0]    newest;
	logic [urh_pkg::PTR_W-1:0]    head_inc;
	logic [urh_pkg::PTR_W-1:0]    rd_addr;
	logic [urh_pkg::SBYTES_W-1:0] rd_bytes_x;
	logic [urh_pkg::SBYTES_W-1:0] push_bytes_x;

	// ring slot arithmetic
	always_comb begin
		tail_sum  = (urh_pkg::CNT_W + 1)'(head_q) + (urh_pkg::CNT_W + 1)'(count_q);
		tail_wrap = (tail_sum >= DEPTH_X) ? (tail_sum - DEPTH_X) : tail_sum;
		tail      = tail_wrap[urh_pkg::PTR_W-1:0];
		newest    = (tail == '0) ? LAST : (tail - urh_pkg::PTR_W'(1));
		head_inc  = (head_q == LAST) ? '0 : (head_q + urh_pkg::PTR_W'(1));
		rd_addr   = cmd.rd_newest ? newest : head_q;
	end

	assign rd_bytes_x   = urh_pkg::SBYTES_W'(rd_q.bytes);
	assign push_bytes_x = urh_pkg::SBYTES_W'(push_entry.bytes);

	// entry storage with registered read
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[tail] <= push_entry;
		end
		if (cmd.rd_newest || cmd.rd_oldest) begin
			rd_q <= mem[rd_addr];
		end
	end

	// head, count and byte sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			bytes_q <= '0;
		end else if (cmd.clr) begin
			head_q  <= '0;
			count_q <= '0;
			bytes_q <= '0;
		end else if (cmd.drop_oldest) begin
			head_q  <= head_inc;
			count_q <= count_q - urh_pkg::CNT_W'(1);
			bytes_q <= bytes_q - rd_bytes_x;
		end else if (cmd.pop_newest) begin
			count_q <= count_q - urh_pkg::CNT_W'(1);
			bytes_q <= bytes_q - rd_bytes_x;
		end else if (cmd.push) begin
			count_q <= count_q + urh_pkg::CNT_W'(1);
			bytes_q <= bytes_q + push_bytes_x;
		end
	end

	assign rd_entry = rd_q;
	assign count    = count_q;
	assign bytes    = bytes_q;
	assign empty    = (count_q == '0);
	assign full     = (count_q == urh_pkg::CNT_W'(urh_pkg::SIDE_DEPTH));

endmodule

[rtl/urh_dp.sv]
module urh_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  urh_pkg::cmd_t        cmd,
	input  logic                 wr_en,
	input  logic                 wr_index,
	input  logic [31:0]          wr_data,
	input  urh_pkg::ctrl_cmd_t   ctl,
	output urh_pkg::dp_stat_t    stat,
	output urh_pkg::rsp_t        rsp
);

	logic [5:0]           max_entries_q;
	logic [31:0]          max_bytes_q;
	urh_pkg::cmd_t        item_q;
	logic [1:0]           status_q;
	logic [15:0]          restored_q;
	logic [31:0]          rev_now_q;
	logic [31:0]          rev_saved_q;
	logic [31:0]          rev_next_q;
	logic [31:0]          push_rev_q;
	logic [6:0]           evict_q;
	urh_pkg::rsp_t        rsp_q;

	urh_pkg::side_cmd_t   ucmd;
	urh_pkg::side_cmd_t   rcmd;
	urh_pkg::entry_t      push_entry;
	urh_pkg::entry_t      urd;
	urh_pkg::entry_t      rrd;
	urh_pkg::entry_t      from_rd;
	logic [urh_pkg::CNT_W-1:0]    ucnt;
	logic [urh_pkg::CNT_W-1:0]    rcnt;
	logic [urh_pkg::SBYTES_W-1:0] ubytes;
	logic [urh_pkg::SBYTES_W-1:0] rbytes;
	logic                 uempty;
	logic                 rempty;
	logic                 ufull;
	logic                 rfull;
	logic [urh_pkg::ECNT_W-1:0]   ent_tot;
	logic [urh_pkg::TBYTES_W-1:0] byte_tot;
	logic                 sel_u;
	logic                 sel_r;

	assign sel_u = (ctl.side == urh_pkg::SIDE_UNDO);
	assign sel_r = (ctl.side == urh_pkg::SIDE_REDO);

	// side operations
	always_comb begin
		ucmd.clr         = ctl.clr;
		ucmd.rd_newest   = ctl.rd_new && sel_u;
		ucmd.rd_oldest   = ctl.rd_old && sel_u;
		ucmd.pop_newest  = ctl.rest && sel_u;
		ucmd.drop_oldest = ctl.drop && sel_u;
		ucmd.push        = ctl.push && sel_u;
		rcmd.clr         = ctl.clr || ctl.rec;
		rcmd.rd_newest   = ctl.rd_new && sel_r;
		rcmd.rd_oldest   = ctl.rd_old && sel_r;
		rcmd.pop_newest  = ctl.rest && sel_r;
		rcmd.drop_oldest = ctl.drop && sel_r;
		rcmd.push        = ctl.push && sel_r;
	end

	assign push_entry.handle = item_q.image_handle;
	assign push_entry.bytes  = item_q.image_bytes;
	assign push_entry.rev    = push_rev_q;

	urh_side u_undo (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (ucmd),
		.push_entry (push_entry),
		.rd_entry   (urd),
		.count      (ucnt),
		.bytes      (ubytes),
		.empty      (uempty),
		.full       (ufull)
	);

	urh_side u_redo (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (rcmd),
		.push_entry (push_entry),
		.rd_entry   (rrd),
		.count      (rcnt),
		.bytes      (rbytes),
		.empty      (rempty),
		.full       (rfull)
	);

	assign from_rd = sel_u ? urd : rrd;

	// trim limits
	always_comb begin
		ent_tot  = urh_pkg::ECNT_W'(ucnt) + urh_pkg::ECNT_W'(rcnt);
		byte_tot = urh_pkg::TBYTES_W'(ubytes) + urh_pkg::TBYTES_W'(rbytes);
	end

	always_comb begin
		stat.mode       = item_q.mode;
		stat.ok         = item_q.action_ok;
		stat.undo_empty = uempty;
		stat.redo_empty = rempty;
		stat.undo_full  = ufull;
		stat.redo_full  = rfull;
		stat.over       = (ent_tot != '0) &&
			((urh_pkg::ECMP_W'(ent_tot) > urh_pkg::ECMP_W'(max_entries_q)) ||
			 (urh_pkg::BCMP_W'(byte_tot) > urh_pkg::BCMP_W'(max_bytes_q)));
		stat.pick_redo  = (ucnt < rcnt);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= 6'd63;
			max_bytes_q   <= '1;
		end else if (wr_en) begin
			if (wr_index == urh_pkg::REG_MAX_ENTRIES) begin
				max_entries_q <= wr_data[5:0];
			end else begin
				max_bytes_q <= wr_data;
			end
		end
	end

	// accepted transaction
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q <= cmd;
		end
	end

	// revisions, status and eviction count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q    <= urh_pkg::ST_OK;
			restored_q  <= '0;
			rev_now_q   <= '0;
			rev_saved_q <= '0;
			rev_next_q  <= 32'd1;
			push_rev_q  <= '0;
			evict_q     <= '0;
		end else begin
			if (ctl.load) begin
				status_q   <= urh_pkg::ST_OK;
				restored_q <= '0;
				evict_q    <= '0;
			end
			if (ctl.status_we) begin
				status_q <= ctl.status;
			end
			if (ctl.drop) begin
				evict_q <= evict_q + 7'd1;
			end
			if (ctl.rec) begin
				push_rev_q <= rev_now_q;
				rev_now_q  <= rev_next_q;
				rev_next_q <= rev_next_q + 32'd1;
			end
			if (ctl.rest) begin
				push_rev_q <= rev_now_q;
				rev_now_q  <= from_rd.rev;
				restored_q <= from_rd.handle;
			end
			if (ctl.save) begin
				rev_saved_q <= rev_now_q;
			end
			if (ctl.clr) begin
				rev_now_q   <= '0;
				rev_saved_q <= '0;
				rev_next_q  <= 32'd1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			rsp_q.status           <= status_q;
			rsp_q.restored_handle  <= restored_q;
			rsp_q.current_revision <= rev_now_q;
			rsp_q.dirty            <= (rev_now_q != rev_saved_q);
			rsp_q.undo_count       <= 7'(ucnt);
			rsp_q.redo_count       <= 7'(rcnt);
			rsp_q.bytes_in_use     <= 32'(byte_tot);
			rsp_q.evicted_count    <= evict_q;
		end
	end

	assign rsp = rsp_q;

endmodule

[rtl/urh_ctrl.sv]
module urh_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	input  urh_pkg::dp_stat_t   stat,
	output urh_pkg::ctrl_cmd_t  ctl
);

	typedef enum logic [8:0] {
		S_IDLE      = 9'b000000001,
		S_DECIDE    = 9'b000000010,
		S_REST      = 9'b000000100,
		S_PD_RD     = 9'b000001000,
		S_PD_DROP   = 9'b000010000,
		S_PUSH      = 9'b000100000,
		S_TRIM_CHK  = 9'b001000000,
		S_TRIM_DROP = 9'b010000000,
		S_DONE      = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   to_side;
	logic   from_side;
	logic   to_full;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign to_side   = (stat.mode == urh_pkg::MODE_UNDO) ? urh_pkg::SIDE_REDO : urh_pkg::SIDE_UNDO;
	assign from_side = ~to_side;
	assign to_full   = (to_side == urh_pkg::SIDE_UNDO) ? stat.undo_full : stat.redo_full;

	// sequencer
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				case (stat.mode)
					urh_pkg::MODE_RECORD: begin
						if (!stat.ok) begin
							ctl.status_we = 1'b1;
							ctl.status    = urh_pkg::ST_FAIL;
							state_d       = S_DONE;
						end else begin
							ctl.rec = 1'b1;
							state_d = stat.undo_full ? S_PD_RD : S_PUSH;
						end
					end
					urh_pkg::MODE_UNDO: begin
						if (stat.undo_empty) begin
							ctl.status_we = 1'b1;
							ctl.status    = urh_pkg::ST_NO_UNDO;
							state_d       = S_DONE;
						end else if (!stat.ok) begin
							ctl.status_we = 1'b1;
							ctl.status    = urh_pkg::ST_FAIL;
							state_d       = S_DONE;
						end else begin
							ctl.rd_new = 1'b1;
							ctl.side   = from_side;
							state_d    = S_REST;
						end
					end
					urh_pkg::MODE_REDO: begin
						if (stat.redo_empty) begin
							ctl.status_we = 1'b1;
							ctl.status    = urh_pkg::ST_NO_REDO;
							state_d       = S_DONE;
						end else if (!stat.ok) begin
							ctl.status_we = 1'b1;
							ctl.status    = urh_pkg::ST_FAIL;
							state_d       = S_DONE;
						end else begin
							ctl.rd_new = 1'b1;
							ctl.side   = from_side;
							state_d    = S_REST;
						end
					end
					urh_pkg::MODE_SAVE: begin
						ctl.save = 1'b1;
						state_d  = S_DONE;
					end
					urh_pkg::MODE_CLEAR: begin
						ctl.clr = 1'b1;
						state_d = S_DONE;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_REST: begin
				ctl.rest = 1'b1;
				ctl.side = from_side;
				state_d  = to_full ? S_PD_RD : S_PUSH;
			end
			S_PD_RD: begin
				ctl.rd_old = 1'b1;
				ctl.side   = to_side;
				state_d    = S_PD_DROP;
			end
			S_PD_DROP: begin
				ctl.drop = 1'b1;
				ctl.side = to_side;
				state_d  = S_PUSH;
			end
			S_PUSH: begin
				ctl.push = 1'b1;
				ctl.side = to_side;
				state_d  = S_TRIM_CHK;
			end
			S_TRIM_CHK: begin
				ctl.side = stat.pick_redo;
				if (stat.over) begin
					ctl.rd_old = 1'b1;
					state_d    = S_TRIM_DROP;
				end else if (out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_TRIM_DROP: begin
				ctl.drop = 1'b1;
				ctl.side = stat.pick_redo;
				state_d  = S_TRIM_CHK;
			end
			S_DONE: begin
				if (out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;

endmodule

[rtl/bounded_undo_redo_history.sv]
// sequence: each transaction is decided first; save, clear, unused modes and rejected
//   commands then go to the result, record pushes, undo/redo restores and then pushes,
//   each evicted entry adds a read and a drop, and the result loads once the output is free;
//   a new transaction is stalled until then, and each side ring has a single registered read port
// reset: both sides empty, revisions cleared, limits at 63 entries and all-ones bytes;
//   entry memories are not cleared
module bounded_undo_redo_history (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  urh_pkg::cmd_t   cmd,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output urh_pkg::rsp_t   rsp,
	input  logic            wr_en,
	input  logic            wr_index,
	input  logic [31:0]     wr_data
);

	urh_pkg::ctrl_cmd_t ctl;
	urh_pkg::dp_stat_t  stat;

	// sequencer
	urh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	// side rings, revisions and result register
	urh_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.ctl      (ctl),
		.stat     (stat),
		.rsp      (rsp)
	);

endmodule
